[design/hsl_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsl_pkg
// Beat types, inter-stage records and fixed-point constants shared by the
// HSLA to RGBA conversion pipeline.
// ----------------------------------------------------------------------------
package hsl_pkg;

    // Q1.15 unity and the hue scale in 1/16 degree
    localparam logic [15:0] Q_ONE       = 16'd32768;
    localparam logic [9:0]  HUE_SECTOR  = 10'd960;
    localparam logic [9:0]  HUE_HALF    = 10'd480;
    // Whole turns added to every hue before the wrap (6 x 5760)
    localparam logic signed [17:0] HUE_BIAS = 18'sd34560;
    // Reciprocals: floor(u/15) for u < 1052 and for u < 491528
    localparam logic [12:0] RECIP15_SHORT = 13'd4370;
    localparam logic [20:0] RECIP15_LONG  = 21'd1118482;
    // floor(q/6) for q < 71
    localparam logic [5:0]  RECIP6        = 6'd43;

    // Sector codes, one per 60 degrees of hue
    localparam logic [2:0] SECT_RED_RISE   = 3'd0;
    localparam logic [2:0] SECT_GREEN_RISE = 3'd1;
    localparam logic [2:0] SECT_GREEN_FALL = 3'd2;
    localparam logic [2:0] SECT_BLUE_RISE  = 3'd3;
    localparam logic [2:0] SECT_BLUE_FALL  = 3'd4;
    localparam logic [2:0] SECT_RED_FALL   = 3'd5;

    typedef struct packed {
        logic signed [15:0] hue;
        logic [15:0]        saturation;
        logic [15:0]        lightness;
        logic [15:0]        alpha_in;
    } hsl_beat_t;

    typedef struct packed {
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
        logic [15:0] alpha_out;
    } rgb_beat_t;

    // Chroma stage result
    typedef struct packed {
        logic [15:0] chroma;
        logic [15:0] light;
        logic [2:0]  sector;
        logic [9:0]  frac;
        logic [15:0] alpha;
    } hsl_chroma_t;

    // Secondary component stage result
    typedef struct packed {
        logic [15:0] second;
        logic [15:0] chroma;
        logic [15:0] light;
        logic [2:0]  sector;
        logic [15:0] alpha;
    } hsl_second_t;

endpackage

[design/hsl_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsl_front
// Two stages: clamp S and L, wrap the hue and find the turn quotient, then
// form the chroma, the sector and the position inside the sector.
// ----------------------------------------------------------------------------
module hsl_front
    import hsl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        up_valid,
    output logic        up_ready,
    input  hsl_beat_t   up_data,
    output logic        dn_valid,
    input  logic        dn_ready,
    output hsl_chroma_t dn_data
);

    // Stage one registers
    logic        s1_valid_reg;
    logic [16:0] s1_turn_reg;
    logic [6:0]  s1_quot_reg;
    logic [15:0] s1_sat_reg;
    logic [15:0] s1_light_reg;
    logic [15:0] s1_span_reg;
    logic [15:0] s1_alpha_reg;

    // Stage two registers
    logic        s2_valid_reg;
    hsl_chroma_t s2_data_reg;

    logic s1_adv;
    logic s2_adv;

    // Stage one logic
    logic signed [17:0] hue_ext;
    logic signed [17:0] hue_sum;
    logic [16:0]        turn_next;
    logic [23:0]        quot_prod;
    logic [6:0]         quot_next;
    logic [15:0]        sat_next;
    logic [15:0]        light_next;
    logic [16:0]        twol;
    logic [16:0]        dev;
    logic [15:0]        span_next;

    // Stage two logic
    logic [16:0] quot960;
    logic [16:0] frac_wide;
    logic [12:0] q6_prod;
    logic [3:0]  q6;
    logic [6:0]  sect_wide;
    logic [31:0] chroma_prod;
    logic [32:0] chroma_sum;
    hsl_chroma_t s2_data_next;

    // Advance a stage when it is empty or its successor takes its beat
    assign s2_adv   = !s2_valid_reg || dn_ready;
    assign s1_adv   = !s1_valid_reg || s2_adv;
    assign up_ready = s1_adv;

    // Wrap hue upward by whole turns, take the 960-unit quotient, clamp S and L
    always_comb
    begin
        hue_ext    = {{2{up_data.hue[15]}}, up_data.hue};
        hue_sum    = hue_ext + HUE_BIAS;
        turn_next  = hue_sum[16:0];
        quot_prod  = turn_next[16:6] * RECIP15_SHORT;
        quot_next  = quot_prod[22:16];
        sat_next   = (up_data.saturation > Q_ONE) ? Q_ONE : up_data.saturation;
        light_next = (up_data.lightness > Q_ONE) ? Q_ONE : up_data.lightness;
        twol       = {light_next, 1'b0};
        dev        = (twol >= {1'b0, Q_ONE}) ? (twol - {1'b0, Q_ONE})
                                             : ({1'b0, Q_ONE} - twol);
        span_next  = 16'({1'b0, Q_ONE} - dev);
    end

    // Chroma, sector and fraction
    always_comb
    begin
        quot960     = {s1_quot_reg, 10'b0} - {4'b0, s1_quot_reg, 6'b0};
        frac_wide   = s1_turn_reg - quot960;
        q6_prod     = s1_quot_reg * RECIP6;
        q6          = q6_prod[11:8];
        sect_wide   = s1_quot_reg - 7'({q6, 2'b0} + {1'b0, q6, 1'b0});
        chroma_prod = s1_span_reg * s1_sat_reg;
        chroma_sum  = {1'b0, chroma_prod} + 33'd16384;
        s2_data_next.chroma = chroma_sum[30:15];
        s2_data_next.light  = s1_light_reg;
        s2_data_next.sector = sect_wide[2:0];
        s2_data_next.frac   = frac_wide[9:0];
        s2_data_next.alpha  = s1_alpha_reg;
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_adv)
            begin
                s1_valid_reg <= up_valid;
            end
            if (s2_adv)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    // Payload, loaded only with a live beat
    always_ff @(posedge clk)
    begin
        if (s1_adv && up_valid)
        begin
            s1_turn_reg  <= turn_next;
            s1_quot_reg  <= quot_next;
            s1_sat_reg   <= sat_next;
            s1_light_reg <= light_next;
            s1_span_reg  <= span_next;
            s1_alpha_reg <= up_data.alpha_in;
        end
        if (s2_adv && s1_valid_reg)
        begin
            s2_data_reg <= s2_data_next;
        end
    end

    assign dn_valid = s2_valid_reg;
    assign dn_data  = s2_data_reg;

endmodule

[design/hsl_second.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsl_second
// Two stages: scale the chroma by the ramp position, then divide by the
// sector width through a reciprocal multiply.
// ----------------------------------------------------------------------------
module hsl_second
    import hsl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        up_valid,
    output logic        up_ready,
    input  hsl_chroma_t up_data,
    output logic        dn_valid,
    input  logic        dn_ready,
    output hsl_second_t dn_data
);

    logic        s3_valid_reg;
    logic [25:0] s3_prod_reg;
    logic [15:0] s3_chroma_reg;
    logic [15:0] s3_light_reg;
    logic [2:0]  s3_sector_reg;
    logic [15:0] s3_alpha_reg;

    logic        s4_valid_reg;
    hsl_second_t s4_data_reg;

    logic s3_adv;
    logic s4_adv;

    logic [9:0]  ramp;
    logic [25:0] prod_next;
    logic [39:0] recip_prod;
    hsl_second_t s4_data_next;

    assign s4_adv   = !s4_valid_reg || dn_ready;
    assign s3_adv   = !s3_valid_reg || s4_adv;
    assign up_ready = s3_adv;

    // Rising ramp in even sectors, falling in odd ones
    always_comb
    begin
        ramp      = up_data.sector[0] ? (HUE_SECTOR - up_data.frac) : up_data.frac;
        prod_next = up_data.chroma * ramp + {16'b0, HUE_HALF};
    end

    // Divide by 960: shift off 64, then multiply by the reciprocal of 15
    always_comb
    begin
        recip_prod          = s3_prod_reg[24:6] * RECIP15_LONG;
        s4_data_next.second = recip_prod[39:24];
        s4_data_next.chroma = s3_chroma_reg;
        s4_data_next.light  = s3_light_reg;
        s4_data_next.sector = s3_sector_reg;
        s4_data_next.alpha  = s3_alpha_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            if (s3_adv)
            begin
                s3_valid_reg <= up_valid;
            end
            if (s4_adv)
            begin
                s4_valid_reg <= s3_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_adv && up_valid)
        begin
            s3_prod_reg   <= prod_next;
            s3_chroma_reg <= up_data.chroma;
            s3_light_reg  <= up_data.light;
            s3_sector_reg <= up_data.sector;
            s3_alpha_reg  <= up_data.alpha;
        end
        if (s4_adv && s3_valid_reg)
        begin
            s4_data_reg <= s4_data_next;
        end
    end

    assign dn_valid = s4_valid_reg;
    assign dn_data  = s4_data_reg;

endmodule

[design/hsl_mix.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsl_mix
// Output stage: route chroma and secondary to channels by sector, add the
// lightness offset with rounding and clamp to one.
// ----------------------------------------------------------------------------
module hsl_mix
    import hsl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        up_valid,
    output logic        up_ready,
    input  hsl_second_t up_data,
    output logic        dn_valid,
    input  logic        dn_ready,
    output rgb_beat_t   dn_data
);

    logic      s5_valid_reg;
    rgb_beat_t s5_data_reg;
    rgb_beat_t s5_data_next;
    logic      s5_adv;

    logic [15:0] red_raw;
    logic [15:0] green_raw;
    logic [15:0] blue_raw;

    // (2v + 2L + 1 - C) / 2, clamped to one
    function automatic logic [15:0] add_offset(
        input logic [15:0] v,
        input logic [15:0] l,
        input logic [15:0] c
    );
        logic [17:0] sum;
        logic [16:0] half;
        sum  = {1'b0, v, 1'b0} + {1'b0, l, 1'b0} + 18'd1 - {2'b0, c};
        half = sum[17:1];
        return (half > {1'b0, Q_ONE}) ? Q_ONE : half[15:0];
    endfunction

    assign s5_adv   = !s5_valid_reg || dn_ready;
    assign up_ready = s5_adv;

    // Route chroma and secondary by sector
    always_comb
    begin
        red_raw   = 16'd0;
        green_raw = 16'd0;
        blue_raw  = 16'd0;
        case (up_data.sector)
            SECT_RED_RISE:
            begin
                red_raw   = up_data.chroma;
                green_raw = up_data.second;
            end
            SECT_GREEN_RISE:
            begin
                red_raw   = up_data.second;
                green_raw = up_data.chroma;
            end
            SECT_GREEN_FALL:
            begin
                green_raw = up_data.chroma;
                blue_raw  = up_data.second;
            end
            SECT_BLUE_RISE:
            begin
                green_raw = up_data.second;
                blue_raw  = up_data.chroma;
            end
            SECT_BLUE_FALL:
            begin
                red_raw  = up_data.second;
                blue_raw = up_data.chroma;
            end
            default:
            begin
                red_raw  = up_data.chroma;
                blue_raw = up_data.second;
            end
        endcase
        s5_data_next.red       = add_offset(red_raw, up_data.light, up_data.chroma);
        s5_data_next.green     = add_offset(green_raw, up_data.light, up_data.chroma);
        s5_data_next.blue      = add_offset(blue_raw, up_data.light, up_data.chroma);
        s5_data_next.alpha_out = up_data.alpha;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s5_valid_reg <= 1'b0;
        end
        else if (s5_adv)
        begin
            s5_valid_reg <= up_valid;
        end
    end

    // Hold the beat while stalled
    always_ff @(posedge clk)
    begin
        if (s5_adv && up_valid)
        begin
            s5_data_reg <= s5_data_next;
        end
    end

    assign dn_valid = s5_valid_reg;
    assign dn_data  = s5_data_reg;

endmodule

[design/hsl_to_rgb_converter.sv]
// Each of the five register stages holds one beat and moves it on when its
// successor is empty or being drained, so the pipeline takes one beat per
// cycle while rgb_stall is low. Reset clears the stage valid bits only; no
// kept state, no clearing pass.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsl_to_rgb_converter
// HSLA to RGBA colour conversion pipeline in Q1.15 fixed point.
// ----------------------------------------------------------------------------
module hsl_to_rgb_converter
    import hsl_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      hsl_valid,
    output logic      hsl_stall,
    input  hsl_beat_t hsl_data,
    output logic      rgb_valid,
    input  logic      rgb_stall,
    output rgb_beat_t rgb_data
);

    logic        front_ready;
    logic        chroma_valid;
    logic        chroma_ready;
    hsl_chroma_t chroma_data;
    logic        second_valid;
    logic        second_ready;
    hsl_second_t second_data;

    assign hsl_stall = !front_ready;

    // Stages one and two: clamp, hue split and chroma
    hsl_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (hsl_valid),
        .up_ready (front_ready),
        .up_data  (hsl_data),
        .dn_valid (chroma_valid),
        .dn_ready (chroma_ready),
        .dn_data  (chroma_data)
    );

    // Stages three and four: secondary component
    hsl_second u_second
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (chroma_valid),
        .up_ready (chroma_ready),
        .up_data  (chroma_data),
        .dn_valid (second_valid),
        .dn_ready (second_ready),
        .dn_data  (second_data)
    );

    // Stage five: channel routing and offset
    hsl_mix u_mix
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (second_valid),
        .up_ready (second_ready),
        .up_data  (second_data),
        .dn_valid (rgb_valid),
        .dn_ready (!rgb_stall),
        .dn_data  (rgb_data)
    );

endmodule

[test/hsl_to_rgb_converter_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsl_to_rgb_converter_tb
// Drives HSLA colours into the conversion pipeline and checks every RGBA beat
// against a fixed-point model kept in the bench. It covers directed corners,
// random colours under mixed idling on both sides, and a long output hold
// that fills the pipeline and pushes back on the input.
// ----------------------------------------------------------------------------
module hsl_to_rgb_converter_tb;
    import hsl_pkg::*;

    // Fixed-point scale used by the colour model, and test lengths
    localparam int ONE_Q15     = 32768;
    localparam int HUE_TURN    = 5760;
    localparam int SECTOR_SPAN = 960;
    localparam int TURN_BIAS   = 34560;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASE_BEATS = 380;
    localparam int DRAIN_WAIT  = 12;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      hsl_valid = 1'b0;
    logic      hsl_stall;
    hsl_beat_t hsl_data = '0;
    logic      rgb_valid;
    logic      rgb_stall = 1'b0;
    rgb_beat_t rgb_data;

    rgb_beat_t expected_rgb[$];
    rgb_beat_t oldest_rgb;
    int        send_idle_pct = 0;
    int        recv_idle_pct = 0;
    logic      hold_req = 1'b0;
    logic      hold_ack = 1'b0;
    int        hold_left = 0;
    int        mismatches = 0;
    int        colours_sent = 0;
    int        colours_checked = 0;

    hsl_to_rgb_converter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .hsl_valid (hsl_valid),
        .hsl_stall (hsl_stall),
        .hsl_data  (hsl_data),
        .rgb_valid (rgb_valid),
        .rgb_stall (rgb_stall),
        .rgb_data  (rgb_data)
    );

    always #1 clk = ~clk;

    // Add the lightness offset to one channel, rounding half up
    function automatic logic [15:0] with_offset(int level, int lit, int chroma);
        int t;
        t = (2 * level + 2 * lit + 1 - chroma) >>> 1;
        return (t > ONE_Q15) ? 16'(ONE_Q15) : 16'(t);
    endfunction

    // Convert one HSLA colour to the RGBA beat the pipeline must return
    function automatic rgb_beat_t convert_hsl(hsl_beat_t px);
        int         hue_w;
        int         sat;
        int         lit;
        int         frac;
        int         dev;
        int         amp;
        int         chroma;
        int         ramp;
        int         second;
        int         r_v;
        int         g_v;
        int         b_v;
        logic [2:0] sector;
        rgb_beat_t  rgb;
        hue_w  = (int'($signed(px.hue)) + TURN_BIAS) % HUE_TURN;
        sat    = (int'(px.saturation) > ONE_Q15) ? ONE_Q15 : int'(px.saturation);
        lit    = (int'(px.lightness) > ONE_Q15) ? ONE_Q15 : int'(px.lightness);
        sector = 3'(hue_w / SECTOR_SPAN);
        frac   = hue_w % SECTOR_SPAN;
        dev    = (2 * lit >= ONE_Q15) ? 2 * lit - ONE_Q15 : ONE_Q15 - 2 * lit;
        amp    = ONE_Q15 - dev;
        chroma = (amp * sat + 16384) >>> 15;
        ramp   = sector[0] ? SECTOR_SPAN - frac : frac;
        second = (chroma * ramp + SECTOR_SPAN / 2) / SECTOR_SPAN;
        r_v = 0;
        g_v = 0;
        b_v = 0;
        // Place chroma and the secondary component by hue sector
        case (sector)
            SECT_RED_RISE:
            begin
                r_v = chroma;
                g_v = second;
            end
            SECT_GREEN_RISE:
            begin
                r_v = second;
                g_v = chroma;
            end
            SECT_GREEN_FALL:
            begin
                g_v = chroma;
                b_v = second;
            end
            SECT_BLUE_RISE:
            begin
                g_v = second;
                b_v = chroma;
            end
            SECT_BLUE_FALL:
            begin
                r_v = second;
                b_v = chroma;
            end
            default:
            begin
                r_v = chroma;
                b_v = second;
            end
        endcase
        rgb.red       = with_offset(r_v, lit, chroma);
        rgb.green     = with_offset(g_v, lit, chroma);
        rgb.blue      = with_offset(b_v, lit, chroma);
        rgb.alpha_out = px.alpha_in;
        return rgb;
    endfunction

    function automatic hsl_beat_t make_colour(int h, int s, int l, int a);
        hsl_beat_t px;
        px.hue        = 16'(h);
        px.saturation = 16'(s);
        px.lightness  = 16'(l);
        px.alpha_in   = 16'(a);
        return px;
    endfunction

    // Mostly in range, sometimes the ends, sometimes any 16-bit pattern
    function automatic logic [15:0] random_q15();
        int mode;
        mode = $urandom_range(15);
        case (mode)
            0:       return 16'd0;
            1:       return 16'(ONE_Q15);
            2, 3:    return 16'($urandom);
            default: return 16'($urandom_range(ONE_Q15));
        endcase
    endfunction

    function automatic hsl_beat_t random_colour();
        hsl_beat_t px;
        int        mode;
        mode = $urandom_range(7);
        case (mode)
            0, 1:    px.hue = 16'($urandom);
            2:       px.hue = 16'($urandom_range(5) * SECTOR_SPAN
                                  + $urandom_range(2) - 1);
            default: px.hue = 16'($urandom_range(HUE_TURN - 1));
        endcase
        px.saturation = random_q15();
        px.lightness  = random_q15();
        px.alpha_in   = random_q15();
        return px;
    endfunction

    // Offer one beat after any idle gap; hold it until accepted
    task automatic send_colour(hsl_beat_t px);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            hsl_valid <= 1'b0;
            @(posedge clk);
        end
        hsl_valid <= 1'b1;
        hsl_data  <= px;
        do
        begin
            @(posedge clk);
        end
        while (hsl_stall !== 1'b0);
        expected_rgb.push_back(convert_hsl(px));
        colours_sent++;
    endtask

    // Drop valid and wait for every outstanding beat to come back
    task automatic drain_pipeline();
        hsl_valid <= 1'b0;
        while (expected_rgb.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic test_corners();
        hsl_beat_t corners[$];
        send_idle_pct = 0;
        recv_idle_pct = 0;
        corners.push_back(make_colour(0, 0, 0, 0));
        corners.push_back(make_colour(0, ONE_Q15, 16384, ONE_Q15));
        corners.push_back(make_colour(960, ONE_Q15, 16384, 100));
        corners.push_back(make_colour(1920, ONE_Q15, 16384, 200));
        corners.push_back(make_colour(2880, ONE_Q15, 16384, 300));
        corners.push_back(make_colour(3840, ONE_Q15, 16384, 400));
        corners.push_back(make_colour(4800, ONE_Q15, 16384, 500));
        corners.push_back(make_colour(5759, ONE_Q15, 16384, 65535));
        corners.push_back(make_colour(480, ONE_Q15, 16384, 12345));
        corners.push_back(make_colour(-1, ONE_Q15, 16384, 32769));
        corners.push_back(make_colour(-32768, 20000, 10000, 40000));
        corners.push_back(make_colour(32767, 30000, 25000, 1));
        corners.push_back(make_colour(-5760, 25000, 16384, 2));
        corners.push_back(make_colour(5760, 25000, 16384, 3));
        corners.push_back(make_colour(1440, 65535, 16384, 4));
        corners.push_back(make_colour(2400, ONE_Q15, 65535, 5));
        corners.push_back(make_colour(3360, 40000, 40000, 0));
        corners.push_back(make_colour(4320, 12345, 32767, 6));
        corners.push_back(make_colour(5280, ONE_Q15, 1, 16));
        corners.push_back(make_colour(100, 1, 16385, ONE_Q15));
        corners.push_back(make_colour(1000, 32767, 16383, 7));
        corners.push_back(make_colour(-2881, 65535, 65535, 65535));
        foreach (corners[i])
        begin
            send_colour(corners[i]);
        end
        drain_pipeline();
    endtask

    task automatic test_random_traffic(int sender_gap_pct, int receiver_gap_pct);
        send_idle_pct = sender_gap_pct;
        recv_idle_pct = receiver_gap_pct;
        repeat (PHASE_BEATS)
        begin
            send_colour(random_colour());
        end
        drain_pipeline();
    endtask

    // Hold the output for a long stretch while the sender keeps offering
    task automatic test_output_hold();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req <= ~hold_req;
        repeat (40)
        begin
            send_colour(random_colour());
        end
        drain_pipeline();
    endtask

    // Count the long hold in cycles once it is requested
    always @(posedge clk)
    begin
        if (hold_req != hold_ack)
        begin
            hold_ack  <= hold_req;
            hold_left <= HOLD_CYCLES;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    // Stall the output at random, or throughout a long hold
    always @(posedge clk)
    begin
        rgb_stall <= (hold_left != 0)
                     || (recv_idle_pct != 0 && $urandom_range(99) < recv_idle_pct);
    end

    task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want)
        begin
            mismatches++;
            $display("%0t ns: %s expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    // Compare each accepted RGBA beat with the oldest expected one
    always @(posedge clk)
    begin
        if (rst_n && rgb_valid === 1'b1 && rgb_stall === 1'b0)
        begin
            if (expected_rgb.size() == 0)
            begin
                mismatches++;
                $display("%0t ns: RGBA beat with none expected, expected nothing, actual %h",
                         $time, rgb_data);
            end
            else
            begin
                oldest_rgb = expected_rgb.pop_front();
                check_field("red", oldest_rgb.red, rgb_data.red);
                check_field("green", oldest_rgb.green, rgb_data.green);
                check_field("blue", oldest_rgb.blue, rgb_data.blue);
                check_field("alpha_out", oldest_rgb.alpha_out, rgb_data.alpha_out);
                colours_checked++;
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("timed out with %0d beats outstanding", expected_rgb.size());
        $display("status: fail");
        $finish;
    end

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_corners();
        test_random_traffic(35, 88);
        test_random_traffic(88, 35);
        test_random_traffic(0, 0);
        test_output_hold();
        repeat (DRAIN_WAIT) @(posedge clk);
        $display("sent %0d colours, checked %0d RGBA beats, %0d mismatches",
                 colours_sent, colours_checked, mismatches);
        $display("corners, clamps, hue wrap, mixed idling and a long output hold");
        if (mismatches == 0 && expected_rgb.size() == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

[hsl_to_rgb_converter.f]
design/hsl_pkg.sv
design/hsl_front.sv
design/hsl_second.sv
design/hsl_mix.sv
design/hsl_to_rgb_converter.sv
test/hsl_to_rgb_converter_tb.sv
